// ===== src/cpbd_pkg.sv =====
// ----------------------------------------------------------------------------
// Cassette pulse byte decoder package
// Shared types, register indexes, reset values and the bit gather function.
// ----------------------------------------------------------------------------
package cpbd_pkg;

  localparam int unsigned AddrWidth = 4;

  localparam logic [1:0] REG_CAPTURE_ENABLE = 2'd0;
  localparam logic [1:0] REG_OVERRUN_CYCLES = 2'd1;
  localparam logic [1:0] REG_ONE_BIT_CYCLES = 2'd2;

  localparam logic [15:0] OVERRUN_RESET = 16'd4000;
  localparam logic [15:0] ONE_BIT_RESET = 16'd2000;

  localparam logic [31:0] SYNC_PATTERN = 32'h0000_cc33;
  localparam logic [1:0]  LEVEL_ONE    = 2'b01;
  localparam logic [4:0]  BITS_PER_BYTE = 5'd16;

  localparam logic [1:0] SPK_MID  = 2'd1;
  localparam logic [1:0] SPK_ZERO = 2'd0;
  localparam logic [1:0] SPK_HIGH = 2'd2;

  typedef struct packed {
    logic        capture_enable;
    logic [15:0] overrun_cycles;
    logic [15:0] one_bit_cycles;
  } cfg_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] byte_value;
    logic       byte_is_flush;
    logic       speaker_valid;
    logic [1:0] speaker_level;
  } result_t;

  function automatic logic [7:0] gather_odd_bits(input logic [15:0] s);
    logic [7:0] v;
    for (int k = 0; k < 8; k++) begin
      v[k] = s[2 * k + 1];
    end
    return v;
  endfunction

endpackage

// ===== src/cpbd_cfg.sv =====
// ----------------------------------------------------------------------------
// Cassette pulse byte decoder configuration registers
// APB-style register file holding capture enable and the two gap limits.
// ----------------------------------------------------------------------------
module cpbd_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cpbd_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output cpbd_pkg::cfg_t                 cfg
);

  logic       wr_en;
  logic [1:0] reg_index;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capture_enable <= 1'b0;
      cfg.overrun_cycles <= cpbd_pkg::OVERRUN_RESET;
      cfg.one_bit_cycles <= cpbd_pkg::ONE_BIT_RESET;
    end else if (wr_en) begin
      case (reg_index)
        cpbd_pkg::REG_CAPTURE_ENABLE: cfg.capture_enable <= pwdata[0];
        cpbd_pkg::REG_OVERRUN_CYCLES: cfg.overrun_cycles <= pwdata[15:0];
        cpbd_pkg::REG_ONE_BIT_CYCLES: cfg.one_bit_cycles <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      cpbd_pkg::REG_CAPTURE_ENABLE: prdata = {31'd0, cfg.capture_enable};
      cpbd_pkg::REG_OVERRUN_CYCLES: prdata = {16'd0, cfg.overrun_cycles};
      cpbd_pkg::REG_ONE_BIT_CYCLES: prdata = {16'd0, cfg.one_bit_cycles};
      default:                      prdata = 32'd0;
    endcase
  end

endmodule

// ===== src/cpbd_decode.sv =====
// ----------------------------------------------------------------------------
// Cassette pulse byte decoder core logic
// Holds the decoder state and decodes one registered port write per step.
// ----------------------------------------------------------------------------
module cpbd_decode (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         port_data,
  input  logic [31:0]        cycle_time,
  input  cpbd_pkg::cfg_t     cfg,
  output cpbd_pkg::result_t  res
);

  logic [7:0]  previous_port;
  logic [31:0] pulse_shift;
  logic [4:0]  collected_bits;
  logic        synced;
  logic [31:0] last_change_time;

  logic [31:0] pulse_shift_next;
  logic [4:0]  collected_bits_next;
  logic        synced_next;
  logic [31:0] last_change_time_next;

  logic        changed;
  logic [31:0] gap;
  logic        overrun;
  logic        short_gap;
  logic [3:0]  pad_amount;
  logic [15:0] padded;
  logic [31:0] shifted;
  logic [4:0]  coll_a;
  logic        sync_hit;

  assign changed    = (previous_port[1:0] ^ port_data[1:0]) != 2'b00;
  assign gap        = cycle_time - last_change_time;
  assign overrun    = gap > {16'd0, cfg.overrun_cycles};
  assign short_gap  = gap < {16'd0, cfg.one_bit_cycles};
  assign pad_amount = 4'(cpbd_pkg::BITS_PER_BYTE - collected_bits);
  assign padded     = pulse_shift[15:0] << pad_amount;
  assign shifted    = short_gap ? {pulse_shift[30:0], 1'b1} : {pulse_shift[29:0], 2'b00};
  assign sync_hit   = !synced && short_gap && (shifted == cpbd_pkg::SYNC_PATTERN);

  always_comb begin
    if (synced) begin
      coll_a = collected_bits + (short_gap ? 5'd1 : 5'd2);
    end else if (sync_hit) begin
      coll_a = cpbd_pkg::BITS_PER_BYTE;
    end else begin
      coll_a = collected_bits;
    end
  end

  always_comb begin
    res                   = '0;
    pulse_shift_next      = pulse_shift;
    collected_bits_next   = collected_bits;
    synced_next           = synced;
    last_change_time_next = last_change_time;
    if (changed) begin
      if (cfg.capture_enable) begin
        last_change_time_next = cycle_time;
        if (overrun) begin
          if (collected_bits != 5'd0) begin
            res.byte_valid    = 1'b1;
            res.byte_is_flush = 1'b1;
            res.byte_value    = cpbd_pkg::gather_odd_bits(
                collected_bits < cpbd_pkg::BITS_PER_BYTE ? padded : pulse_shift[15:0]);
          end
          pulse_shift_next    = '0;
          collected_bits_next = '0;
          synced_next         = 1'b0;
        end else if (port_data[1:0] == cpbd_pkg::LEVEL_ONE) begin
          synced_next = synced || sync_hit;
          if (coll_a >= cpbd_pkg::BITS_PER_BYTE) begin
            res.byte_valid      = 1'b1;
            res.byte_value      = cpbd_pkg::gather_odd_bits(shifted[15:0]);
            collected_bits_next = coll_a - cpbd_pkg::BITS_PER_BYTE;
            pulse_shift_next    = '0;
          end else begin
            collected_bits_next = coll_a;
            pulse_shift_next    = shifted;
          end
        end
      end else begin
        res.speaker_valid = 1'b1;
        case (port_data[1:0])
          2'b00:   res.speaker_level = cpbd_pkg::SPK_MID;
          2'b10:   res.speaker_level = cpbd_pkg::SPK_HIGH;
          default: res.speaker_level = cpbd_pkg::SPK_ZERO;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_port    <= '0;
      pulse_shift      <= '0;
      collected_bits   <= '0;
      synced           <= 1'b0;
      last_change_time <= '0;
    end else if (step) begin
      previous_port    <= port_data;
      pulse_shift      <= pulse_shift_next;
      collected_bits   <= collected_bits_next;
      synced           <= synced_next;
      last_change_time <= last_change_time_next;
    end
  end

endmodule

// ===== src/cassette_pulse_byte_decoder_core.sv =====
// ----------------------------------------------------------------------------
// Cassette pulse byte decoder
// Decodes timed cassette port writes into bytes or speaker levels.
// ----------------------------------------------------------------------------
// Usage:
// Each port write enters on the s_ stream channel as one transfer carrying
// the written value and its cycle timestamp. Every input transfer yields
// exactly one result transfer on the m_ channel, in order; the result tells
// whether a byte was decoded (and whether it is a flush of a partial byte)
// and whether a speaker level applies.
// An accepted item is held in an input register and then decoded into the
// result register, which drives the m_ channel. One item is accepted every
// cycle while the output is taken; the rate is set by the single decode step
// between those two registers. When the receiver stalls, the result holds and
// the input register still takes one more item; further input waits until
// the result is taken. Reset clears both registers, the decoder state and the
// configuration registers to capture off, overrun limit 4000 and one-bit
// limit 2000. Configuration should be written through the APB port only while
// no item is pending; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module cassette_pulse_byte_decoder_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [7:0] port_data, [39:8] cycle_time
  input  logic [39:0]                    s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [0] byte_valid, [8:1] byte_value, [9] speaker_valid, [11:10] speaker_level,
  // [15:12] zero
  output logic [15:0]                    m_tdata,
  // [0] byte_is_flush
  output logic [0:0]                     m_tuser,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cpbd_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  cpbd_pkg::cfg_t    cfg;
  cpbd_pkg::result_t res;
  cpbd_pkg::result_t out_res;

  logic        in_valid;
  logic [7:0]  in_port;
  logic [31:0] in_time;
  logic        out_valid;
  logic        advance;

  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_port <= s_tdata[7:0];
      in_time <= s_tdata[39:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_res <= res;
    end
  end

  cpbd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cpbd_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .step       (advance && in_valid),
    .port_data  (in_port),
    .cycle_time (in_time),
    .cfg        (cfg),
    .res        (res)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, out_res.speaker_level, out_res.speaker_valid,
                     out_res.byte_value, out_res.byte_valid};
  assign m_tuser  = out_res.byte_is_flush;

endmodule

// ===== src/cpbd_checker.sv =====
// ----------------------------------------------------------------------------
// Cassette pulse byte decoder checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module cpbd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [0:0]  m_tuser
);

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("Result valid after reset.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("Stalled result changed.");

  a_flush_has_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[0])
    else $error("Flush marked without a byte.");

  a_byte_or_speaker: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[9]))
    else $error("Byte and speaker level in one result.");

  a_speaker_level_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[11:10] != 2'b11) && (m_tdata[15:12] == 4'd0))
    else $error("Illegal speaker level or padding.");

endmodule

bind cassette_pulse_byte_decoder_core cpbd_checker u_cpbd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== test/cassette_pulse_byte_decoder_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cassette pulse byte decoder testbench
// Sends timed port writes as stream transfers, decodes each one in a local
// model of the tape decoder and checks every result transfer field by field.
// A short table covers speaker levels, sync detection and overrun flushes.
// Random tape blocks and noise then follow under several register settings
// and idling patterns.
// ----------------------------------------------------------------------------
module cassette_pulse_byte_decoder_core_tb;

  typedef enum logic {ROW_WRITE, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [1:0]         reg_index;
    logic [15:0]        reg_value;
    logic [7:0]         port;
    logic [31:0]        stamp;
    logic               typed;
    cpbd_pkg::result_t  want;
  } directed_row_t;

  localparam logic [11:0]       SYNC_PULSES    = 12'b1101_1001_1011;
  localparam logic [1:0]        LEVEL_LOW      = 2'd0;
  localparam logic [1:0]        LEVEL_HIGH     = 2'd2;
  localparam cpbd_pkg::result_t NO_RESULT      = '0;
  localparam int                PhaseCount     = 6;
  localparam int                WritesPerPhase = 215;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [39:0]                    s_tdata = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [15:0]                    m_tdata;
  logic [0:0]                     m_tuser;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [cpbd_pkg::AddrWidth-1:0] paddr = '0;
  logic [31:0]                    pwdata = '0;
  logic [31:0]                    prdata;
  logic                           pready;

  cpbd_pkg::cfg_t model_cfg;
  logic [7:0]     model_prev_port;
  logic [31:0]    model_shift;
  logic [4:0]     model_bits;
  logic           model_synced;
  logic [31:0]    model_last_change;

  cpbd_pkg::result_t pending_decodes[$];
  logic              drive_typed = 1'b0;
  cpbd_pkg::result_t drive_want = '0;
  logic [31:0]       tape_clock = '0;
  logic [1:0]        last_level = 2'd0;
  int                src_idle_pct = 0;
  int                sink_stall_pct = 0;
  int                error_count = 0;
  int                writes_sent = 0;
  int                writes_accepted = 0;
  int                bytes_seen = 0;
  int                flushes_seen = 0;
  int                speaker_seen = 0;

  cassette_pulse_byte_decoder_core dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99, 0) >= sink_stall_pct);
  end

  function automatic logic [7:0] data_bits_of(input logic [31:0] s);
    logic [7:0] v;
    for (int k = 0; k < 8; k++) begin
      v[k] = s[2 * k + 1];
    end
    return v;
  endfunction

  function automatic cpbd_pkg::result_t decode_write(input logic [7:0] data,
                                                     input logic [31:0] now);
    cpbd_pkg::result_t r;
    logic [31:0]       gap;
    logic [31:0]       padded;
    r = '0;
    gap = now - model_last_change;
    if ((model_prev_port[1:0] ^ data[1:0]) != 2'b00) begin
      if (model_cfg.capture_enable) begin
        if (gap > {16'd0, model_cfg.overrun_cycles}) begin
          if (model_bits != 5'd0) begin
            padded = model_shift;
            if (model_bits < cpbd_pkg::BITS_PER_BYTE) begin
              padded = padded << (cpbd_pkg::BITS_PER_BYTE - model_bits);
            end
            r.byte_valid = 1'b1;
            r.byte_value = data_bits_of(padded);
            r.byte_is_flush = 1'b1;
          end
          model_shift = '0;
          model_bits = '0;
          model_synced = 1'b0;
        end else if (data[1:0] == cpbd_pkg::LEVEL_ONE) begin
          if (gap < {16'd0, model_cfg.one_bit_cycles}) begin
            model_shift = {model_shift[30:0], 1'b1};
            if (model_synced) begin
              model_bits = model_bits + 5'd1;
            end else if (model_shift == cpbd_pkg::SYNC_PATTERN) begin
              model_synced = 1'b1;
              model_bits = cpbd_pkg::BITS_PER_BYTE;
            end
          end else begin
            model_shift = model_shift << 2;
            if (model_synced) begin
              model_bits = model_bits + 5'd2;
            end
          end
          if (model_bits >= cpbd_pkg::BITS_PER_BYTE) begin
            r.byte_valid = 1'b1;
            r.byte_value = data_bits_of(model_shift);
            model_bits = model_bits - cpbd_pkg::BITS_PER_BYTE;
            model_shift = '0;
          end
        end
        model_last_change = now;
      end else begin
        r.speaker_valid = 1'b1;
        case (data[1:0])
          LEVEL_LOW:  r.speaker_level = cpbd_pkg::SPK_MID;
          LEVEL_HIGH: r.speaker_level = cpbd_pkg::SPK_HIGH;
          default:    r.speaker_level = cpbd_pkg::SPK_ZERO;
        endcase
      end
    end
    model_prev_port = data;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    cpbd_pkg::result_t predicted;
    cpbd_pkg::result_t oldest;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        bytes_seen += m_tdata[0];
        flushes_seen += m_tuser[0];
        speaker_seen += m_tdata[9];
        if (pending_decodes.size() == 0) begin
          $display("%0t: result transfer with no write pending, expected none, actual %h/%h",
                   $time, m_tdata, m_tuser);
          error_count++;
        end else begin
          oldest = pending_decodes.pop_front();
          check_field("byte_valid", oldest.byte_valid, m_tdata[0]);
          check_field("byte_value", oldest.byte_value, m_tdata[8:1]);
          check_field("byte_is_flush", oldest.byte_is_flush, m_tuser[0]);
          check_field("speaker_valid", oldest.speaker_valid, m_tdata[9]);
          check_field("speaker_level", oldest.speaker_level, m_tdata[11:10]);
          check_field("tdata padding", 0, m_tdata[15:12]);
        end
      end
      if (s_tvalid && s_tready) begin
        predicted = decode_write(s_tdata[7:0], s_tdata[39:8]);
        pending_decodes.push_back(drive_typed ? drive_want : predicted);
        writes_accepted++;
      end
    end
  end

  task automatic send_write(input logic [7:0] data, input logic [31:0] stamp,
                            input logic typed, input cpbd_pkg::result_t want);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {stamp, data};
    drive_typed <= typed;
    drive_want <= want;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    last_level = data[1:0];
    writes_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [15:0] value);
    logic [31:0] readback;
    readback = (index == cpbd_pkg::REG_CAPTURE_ENABLE) ? {31'd0, value[0]} : {16'd0, value};
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {index, 2'b00};
    pwdata <= {16'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (index)
      cpbd_pkg::REG_CAPTURE_ENABLE: model_cfg.capture_enable = value[0];
      cpbd_pkg::REG_OVERRUN_CYCLES: model_cfg.overrun_cycles = value;
      cpbd_pkg::REG_ONE_BIT_CYCLES: model_cfg.one_bit_cycles = value;
      default: ;
    endcase
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== readback) begin
      $display("%0t: register %0d readback mismatch, expected %h, actual %h",
               $time, index, readback, prdata);
      error_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic capture, input logic [15:0] overrun,
                               input logic [15:0] one_bit, input int src_pct, input int sink_pct);
    wait_idle();
    write_register(cpbd_pkg::REG_OVERRUN_CYCLES, overrun);
    write_register(cpbd_pkg::REG_ONE_BIT_CYCLES, one_bit);
    write_register(cpbd_pkg::REG_CAPTURE_ENABLE, {15'd0, capture});
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  function automatic logic [1:0] other_level();
    logic [1:0] lvl;
    lvl = 2'($urandom_range(3, 0));
    while (lvl == cpbd_pkg::LEVEL_ONE || lvl == last_level) begin
      lvl = 2'($urandom_range(3, 0));
    end
    return lvl;
  endfunction

  function automatic logic [31:0] short_gap();
    if (model_cfg.one_bit_cycles == 16'd0) return 32'd0;
    if ($urandom_range(7, 0) == 0) return {16'd0, model_cfg.one_bit_cycles - 16'd1};
    return $urandom_range({16'd0, model_cfg.one_bit_cycles - 16'd1}, 0);
  endfunction

  function automatic logic [31:0] long_gap();
    logic [31:0] lo;
    lo = (model_cfg.one_bit_cycles > model_cfg.overrun_cycles) ?
         {16'd0, model_cfg.overrun_cycles} : {16'd0, model_cfg.one_bit_cycles};
    if ($urandom_range(7, 0) == 0) return lo;
    return $urandom_range({16'd0, model_cfg.overrun_cycles}, lo);
  endfunction

  function automatic logic [31:0] overrun_gap();
    if ($urandom_range(3, 0) == 0) return 32'hFFFF_FFFF - $urandom_range(5000, 0);
    return {16'd0, model_cfg.overrun_cycles} + 32'd1 + $urandom_range(3000, 0);
  endfunction

  task automatic send_level(input logic [1:0] lvl, input logic [31:0] gap);
    logic [5:0] upper;
    upper = 6'($urandom_range(63, 0));
    tape_clock = tape_clock + gap;
    send_write({upper, lvl}, tape_clock, 1'b0, NO_RESULT);
  endtask

  task automatic tape_pulse(input logic one);
    logic [31:0] gap;
    gap = ($urandom_range(7, 0) == 0) ? {16'd0, model_cfg.overrun_cycles} :
          $urandom_range({16'd0, model_cfg.overrun_cycles}, 0);
    send_level(other_level(), gap);
    send_level(cpbd_pkg::LEVEL_ONE, one ? short_gap() : long_gap());
  endtask

  task automatic tape_block();
    int flip;
    int pulses;
    flip = ($urandom_range(9, 0) == 0) ? int'($urandom_range(11, 0)) : -1;
    pulses = $urandom_range(64, 1);
    if ($urandom_range(3, 0) == 0) tape_clock = $urandom;
    send_level(other_level(), overrun_gap());
    for (int k = 11; k >= 0; k--) begin
      tape_pulse(SYNC_PULSES[k] ^ (k == flip));
    end
    repeat (pulses) tape_pulse(1'($urandom_range(1, 0)));
    if ($urandom_range(1, 0) == 1) send_level(other_level(), overrun_gap());
  endtask

  task automatic noise_block();
    int          n;
    logic [31:0] gap;
    n = $urandom_range(12, 1);
    repeat (n) begin
      case ($urandom_range(4, 0))
        0:       gap = short_gap();
        1:       gap = long_gap();
        2:       gap = overrun_gap();
        3:       gap = $urandom;
        default: gap = $urandom_range(3, 0);
      endcase
      tape_clock = tape_clock + gap;
      send_write(8'($urandom), tape_clock, 1'b0, NO_RESULT);
    end
  endtask

  function automatic cpbd_pkg::result_t make_result(input logic bv, input logic [7:0] value,
                                                    input logic flush, input logic sv,
                                                    input logic [1:0] level);
    cpbd_pkg::result_t r;
    r.byte_valid = bv;
    r.byte_value = value;
    r.byte_is_flush = flush;
    r.speaker_valid = sv;
    r.speaker_level = level;
    return r;
  endfunction

  function automatic directed_row_t write_row(input logic [7:0] port, input logic [31:0] stamp);
    directed_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.port = port;
    row.stamp = stamp;
    return row;
  endfunction

  function automatic directed_row_t checked_row(input logic [7:0] port, input logic [31:0] stamp,
                                                input cpbd_pkg::result_t want);
    directed_row_t row;
    row = write_row(port, stamp);
    row.typed = 1'b1;
    row.want = want;
    return row;
  endfunction

  function automatic directed_row_t reg_row(input logic [1:0] index, input logic [15:0] value);
    directed_row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.reg_index = index;
    row.reg_value = value;
    return row;
  endfunction

  initial begin : stimulus
    directed_row_t dir_rows[$];
    int            phase_start;
    logic          drained_mid;
    logic [15:0]   overrun;
    model_cfg.capture_enable = 1'b0;
    model_cfg.overrun_cycles = cpbd_pkg::OVERRUN_RESET;
    model_cfg.one_bit_cycles = cpbd_pkg::ONE_BIT_RESET;
    model_prev_port = '0;
    model_shift = '0;
    model_bits = '0;
    model_synced = 1'b0;
    model_last_change = '0;
    drained_mid = 1'b0;

    dir_rows.push_back(checked_row(8'h00, 32'd0, NO_RESULT));
    dir_rows.push_back(checked_row(8'h02, 32'd10,
                                   make_result(0, 0, 0, 1, cpbd_pkg::SPK_HIGH)));
    dir_rows.push_back(checked_row(8'hFB, 32'd20,
                                   make_result(0, 0, 0, 1, cpbd_pkg::SPK_ZERO)));
    dir_rows.push_back(checked_row(8'hFC, 32'hFFFF_FFFF,
                                   make_result(0, 0, 0, 1, cpbd_pkg::SPK_MID)));
    dir_rows.push_back(reg_row(cpbd_pkg::REG_OVERRUN_CYCLES, cpbd_pkg::OVERRUN_RESET));
    dir_rows.push_back(reg_row(cpbd_pkg::REG_ONE_BIT_CYCLES, cpbd_pkg::ONE_BIT_RESET));
    dir_rows.push_back(reg_row(cpbd_pkg::REG_CAPTURE_ENABLE, 16'd1));
    dir_rows.push_back(write_row(8'h01, 32'd500));
    dir_rows.push_back(write_row(8'h00, 32'd4500));
    dir_rows.push_back(write_row(8'h01, 32'd5000));
    dir_rows.push_back(write_row(8'h02, 32'd5100));
    dir_rows.push_back(write_row(8'h01, 32'd7100));
    dir_rows.push_back(write_row(8'h03, 32'd7200));
    dir_rows.push_back(write_row(8'h01, 32'd7300));
    dir_rows.push_back(write_row(8'h00, 32'd7400));
    dir_rows.push_back(write_row(8'h01, 32'd7500));
    dir_rows.push_back(write_row(8'h02, 32'd7600));
    dir_rows.push_back(write_row(8'h01, 32'd10000));
    dir_rows.push_back(write_row(8'h03, 32'd10100));
    dir_rows.push_back(write_row(8'h01, 32'd13000));
    dir_rows.push_back(write_row(8'h00, 32'd13100));
    dir_rows.push_back(write_row(8'h01, 32'd13200));
    dir_rows.push_back(write_row(8'h02, 32'd13300));
    dir_rows.push_back(write_row(8'h01, 32'd13400));
    dir_rows.push_back(write_row(8'h03, 32'd13500));
    dir_rows.push_back(write_row(8'h01, 32'd16000));
    dir_rows.push_back(write_row(8'h00, 32'd16100));
    dir_rows.push_back(write_row(8'h01, 32'd16200));
    dir_rows.push_back(write_row(8'h02, 32'd16300));
    dir_rows.push_back(checked_row(8'h01, 32'd16400,
                                   make_result(1, 8'hA5, 0, 0, cpbd_pkg::SPK_ZERO)));
    dir_rows.push_back(write_row(8'h00, 32'd16500));
    dir_rows.push_back(write_row(8'h01, 32'd16600));
    dir_rows.push_back(checked_row(8'hFF, 32'd46600,
                                   make_result(1, 8'h80, 1, 0, cpbd_pkg::SPK_ZERO)));
    dir_rows.push_back(checked_row(8'h00, 32'd100, NO_RESULT));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        wait_idle();
        write_register(dir_rows[i].reg_index, dir_rows[i].reg_value);
      end else begin
        send_write(dir_rows[i].port, dir_rows[i].stamp, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int phase = 0; phase < PhaseCount; phase++) begin
      overrun = 16'($urandom_range(65535, 2000));
      case (phase)
        0:       apply_setting(1'b1, 16'd4000, 16'd2000, 0, 0);
        1:       apply_setting(1'b1, 16'hFFFF, 16'hFFFF, 75, 0);
        2:       apply_setting(1'b1, 16'd0, 16'd0, 0, 75);
        3:       apply_setting(1'b0, overrun, 16'($urandom), 17, 17);
        4:       apply_setting(1'b1, overrun, 16'($urandom_range(overrun, 1)), 17, 17);
        default: apply_setting(1'b1, 16'd1000, 16'd300, 0, 0);
      endcase
      phase_start = writes_sent;
      while (writes_sent - phase_start < WritesPerPhase) begin
        if (phase == 0 && !drained_mid && writes_sent - phase_start >= WritesPerPhase / 2) begin
          wait_idle();
          drained_mid = 1'b1;
        end
        if (model_cfg.capture_enable && $urandom_range(4, 0) != 0) begin
          tape_block();
        end else begin
          noise_block();
        end
      end
    end

    wait_idle();
    $display("Checked %0d port writes under %0d register settings with four idling patterns.",
             writes_accepted, PhaseCount + 1);
    $display("Results carried %0d decoded bytes, %0d of them flushed, and %0d speaker levels.",
             bytes_seen, flushes_seen, speaker_seen);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== cassette_pulse_byte_decoder_core.f =====
src/cpbd_pkg.sv
src/cpbd_cfg.sv
src/cpbd_decode.sv
src/cassette_pulse_byte_decoder_core.sv
src/cpbd_checker.sv
test/cassette_pulse_byte_decoder_core_tb.sv
